FILE: hdl/spims_pkg.sv
// Shared types, register indexes and rate decode for the SPI master byte shifter.
`timescale 1ns / 1ps
`default_nettype none
package spims_pkg;

  // Configuration port geometry
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LSB_FIRST = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_POLARITY  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RATE      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_IRQ_EN    = 3'd5;

  // Rate select codes
  localparam logic [2:0] RATE_DIV4   = 3'd0;
  localparam logic [2:0] RATE_DIV16  = 3'd1;
  localparam logic [2:0] RATE_DIV64  = 3'd2;
  localparam logic [2:0] RATE_DIV128 = 3'd3;
  localparam logic [2:0] RATE_DIV2   = 3'd4;

  // Transaction kinds
  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_READ   = 2'd2,
    MODE_STATUS = 2'd3
  } mode_t;

  typedef struct packed {
    logic       enable;
    logic       lsb_first;
    logic       clock_polarity;
    logic       clock_phase;
    logic [2:0] rate_select;
    logic       irq_enable;
  } cfg_t;

  // Side effects of a register write on the shifter state
  typedef struct packed {
    logic abort;    // enable written to 0
    logic pol_wr;   // polarity written
    logic pol_val;
  } cfg_evt_t;

  typedef struct packed {
    logic       mosi_level;
    logic       sck_level;
    logic       busy_res;
    logic       irq_request;
    logic       complete_flag;
    logic [7:0] read_byte;
  } result_t;

  // Ticks per SCK half period
  function automatic logic [6:0] half_period(input logic [2:0] rate);
    logic [6:0] half;
    unique case (rate)
      RATE_DIV16:  half = 7'd8;
      RATE_DIV64:  half = 7'd32;
      RATE_DIV128: half = 7'd64;
      RATE_DIV2:   half = 7'd1;
      default:     half = 7'd2;
    endcase
    return half;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/spi_master_byte_shifter.sv
// Top level of the SPI master byte shifter.
//
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   in_tuser: mode; in_tdata: write_byte, miso_bit
//  out_     out  out_tvalid/out_tready out_tdata: read_byte .. mosi_level
//  cfg_     in   cfg_we                cfg_addr, cfg_wdata
//
// Each transaction is folded into the shifter state in the cycle it is accepted;
// its result appears on out_ the next cycle, one transaction per cycle while out_ accepts.
// The single result register sets the rate: input is taken while it is empty or
// being drained, so a stall on out_ holds in_tready low.
// Reset (rst_n, synchronous) clears registers, state and the result valid flag.
`timescale 1ns / 1ps
`default_nettype none
module spi_master_byte_shifter (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [15:0]                     in_tdata,   // write_byte[7:0], miso_bit[8], zero pad
  input  wire  [1:0]                      in_tuser,   // mode[1:0]
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [15:0]                     out_tdata,  // read_byte[7:0], complete_flag[8],
                                                      // irq_request[9], busy_res[10],
                                                      // sck_level[11], mosi_level[12], pad
  input  wire                             cfg_we,
  input  wire  [spims_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire  [spims_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import spims_pkg::*;

  cfg_t     cfg;
  cfg_evt_t evt;
  result_t  res;
  result_t  out_res;
  logic     accept;

  assign accept = in_tvalid && in_tready;

  spims_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .evt       (evt)
  );

  spims_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (accept),
    .item_mode  (in_tuser),
    .item_wbyte (in_tdata[7:0]),
    .item_miso  (in_tdata[8]),
    .cfg        (cfg),
    .evt        (evt),
    .res        (res)
  );

  spims_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .res        (res),
    .ready      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  // Pack the result, read_byte lowest and mosi_level highest
  assign out_tdata = {3'd0, out_res.mosi_level, out_res.sck_level, out_res.busy_res,
                      out_res.irq_request, out_res.complete_flag, out_res.read_byte};

endmodule
`default_nettype wire

FILE: hdl/spims_cfg.sv
// Configuration register file and write side-effect decode.
`timescale 1ns / 1ps
`default_nettype none
module spims_cfg (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire  [spims_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire  [spims_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output spims_pkg::cfg_t                 cfg,
  output spims_pkg::cfg_evt_t             evt
);
  import spims_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_ENABLE:    cfg_nxt.enable         = cfg_wdata[0];
        REG_LSB_FIRST: cfg_nxt.lsb_first      = cfg_wdata[0];
        REG_POLARITY:  cfg_nxt.clock_polarity = cfg_wdata[0];
        REG_PHASE:     cfg_nxt.clock_phase    = cfg_wdata[0];
        REG_RATE:      cfg_nxt.rate_select    = cfg_wdata;
        REG_IRQ_EN:    cfg_nxt.irq_enable     = cfg_wdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Writes that act on the shifter in the same cycle
  assign evt.abort   = cfg_we && (cfg_addr == REG_ENABLE) && !cfg_wdata[0];
  assign evt.pol_wr  = cfg_we && (cfg_addr == REG_POLARITY);
  assign evt.pol_val = cfg_wdata[0];

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: hdl/spims_engine.sv
// Shifter state: prescaler, edge counter, shift register and flags, one transaction a cycle.
`timescale 1ns / 1ps
`default_nettype none
module spims_engine (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  item_vld,
  input  wire  [1:0]           item_mode,
  input  wire  [7:0]           item_wbyte,
  input  wire                  item_miso,
  input  spims_pkg::cfg_t      cfg,
  input  spims_pkg::cfg_evt_t  evt,
  output spims_pkg::result_t   res
);
  import spims_pkg::*;

  logic [7:0] shift_r, shift_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic [3:0] edge_r, edge_nxt;
  logic [5:0] presc_r, presc_nxt;
  logic       sck_r, sck_nxt;
  logic       mosi_r, mosi_nxt;
  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;

  logic [7:0] rd;
  logic [6:0] presc_inc;
  logic [7:0] shifted;
  logic       out_bit;
  logic       wr_bit;
  logic       leading;
  logic       last_edge;
  mode_t      mode;

  assign mode      = mode_t'(item_mode);
  assign presc_inc = {1'b0, presc_r} + 7'd1;
  assign shifted   = cfg.lsb_first ? {item_miso, shift_r[7:1]} : {shift_r[6:0], item_miso};
  assign out_bit   = cfg.lsb_first ? shift_r[0] : shift_r[7];
  assign wr_bit    = cfg.lsb_first ? item_wbyte[0] : item_wbyte[7];
  assign leading   = ~edge_r[0];
  assign last_edge = (edge_r == 4'hF);

  // Next state for one transaction, then register-write side effects
  always_comb begin
    shift_nxt = shift_r;
    rx_nxt    = rx_r;
    edge_nxt  = edge_r;
    presc_nxt = presc_r;
    sck_nxt   = sck_r;
    mosi_nxt  = mosi_r;
    busy_nxt  = busy_r;
    done_nxt  = done_r;
    rd        = '0;
    if (item_vld) begin
      unique case (mode)
        MODE_TICK: begin
          if (busy_r) begin
            if (presc_inc >= half_period(cfg.rate_select)) begin
              presc_nxt = '0;
              sck_nxt   = ~sck_r;
              if (!cfg.clock_phase) begin
                if (leading) shift_nxt = shifted;
                else if (!last_edge) mosi_nxt = out_bit;
              end else begin
                if (leading) mosi_nxt = out_bit;
                else shift_nxt = shifted;
              end
              if (last_edge) begin
                rx_nxt   = shift_nxt;
                done_nxt = 1'b1;
                busy_nxt = 1'b0;
                edge_nxt = '0;
                sck_nxt  = cfg.clock_polarity;
              end else begin
                edge_nxt = edge_r + 4'd1;
              end
            end else begin
              presc_nxt = presc_inc[5:0];
            end
          end
        end
        MODE_WRITE: begin
          done_nxt = 1'b0;
          if (cfg.enable && !busy_r) begin
            shift_nxt = item_wbyte;
            busy_nxt  = 1'b1;
            edge_nxt  = '0;
            presc_nxt = '0;
            sck_nxt   = cfg.clock_polarity;
            if (!cfg.clock_phase) mosi_nxt = wr_bit;
          end
        end
        MODE_READ: begin
          rd       = rx_r;
          done_nxt = 1'b0;
        end
        MODE_STATUS: begin
          rd = {done_r, 6'd0, (cfg.rate_select == RATE_DIV2)};
        end
        default: rd = '0;
      endcase
    end
    // Enable cleared mid-transfer aborts it
    if (evt.abort && busy_nxt) begin
      busy_nxt  = 1'b0;
      edge_nxt  = '0;
      presc_nxt = '0;
      sck_nxt   = cfg.clock_polarity;
    end
    // Polarity write moves an idle SCK at once
    if (evt.pol_wr && !busy_nxt) sck_nxt = evt.pol_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      rx_r    <= '0;
      edge_r  <= '0;
      presc_r <= '0;
      sck_r   <= 1'b0;
      mosi_r  <= 1'b0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      rx_r    <= rx_nxt;
      edge_r  <= edge_nxt;
      presc_r <= presc_nxt;
      sck_r   <= sck_nxt;
      mosi_r  <= mosi_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
  end

  // Result reflects the state after this transaction
  assign res.read_byte     = rd;
  assign res.complete_flag = done_nxt;
  assign res.irq_request   = done_nxt & cfg.irq_enable;
  assign res.busy_res      = busy_nxt;
  assign res.sck_level     = sck_nxt;
  assign res.mosi_level    = mosi_nxt;

  // Counters rest at zero whenever no transfer runs
  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (edge_r == 4'd0) && (presc_r == 6'd0))
    else $error("counters not cleared while idle");

  // Idle SCK sits at the configured polarity
  a_idle_sck: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (sck_r == cfg.clock_polarity))
    else $error("idle SCK differs from polarity");

  // Complete flag is only raised by the end of a transfer
  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> $fell(busy_r))
    else $error("complete flag set without transfer end");

endmodule
`default_nettype wire

FILE: hdl/spims_out.sv
// Result register between the shifter and the output stream.
`timescale 1ns / 1ps
`default_nettype none
module spims_out (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  spims_pkg::result_t  res,
  output logic                ready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output spims_pkg::result_t  out_res
);
  import spims_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Take a new result when empty or when the held one leaves this cycle
  assign ready     = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule
`default_nettype wire
